### rtl/core/q248_pkg.sv
package q248_pkg;

   typedef enum logic [3:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_MIN     = 4'd4,
      OP_MAX     = 4'd5,
      OP_LT      = 4'd6,
      OP_LE      = 4'd7,
      OP_GT      = 4'd8,
      OP_GE      = 4'd9,
      OP_EQ      = 4'd10,
      OP_NE      = 4'd11,
      OP_INC     = 4'd12,
      OP_DEC     = 4'd13,
      OP_TOINT   = 4'd14,
      OP_FROMINT = 4'd15
   } opcode_type;

   localparam logic [1:0] ERR_OK   = 2'd0;
   localparam logic [1:0] ERR_OVF  = 2'd1;
   localparam logic [1:0] ERR_DIV0 = 2'd2;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] value;
      logic               cond;
      logic [1:0]         err;
   } result_type;

   // Clamps a 33-bit signed sum to the 32-bit range.
   function automatic result_type sat33(input logic signed [32:0] v);
      result_type r;
      r.cond = 1'b0;
      if (v[32] != v[31]) begin
         r.value = v[32] ? Q_MIN : Q_MAX;
         r.err   = ERR_OVF;
      end else begin
         r.value = v[31:0];
         r.err   = ERR_OK;
      end
      return r;
   endfunction

endpackage

### rtl/core/q248_mul.sv
module q248_mul #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                clock,
   input  logic                en,
   input  logic [31:0]         mag_a,
   input  logic [31:0]         mag_b,
   input  logic                neg,
   output q248_pkg::result_type res
);
   import q248_pkg::*;

   localparam int MW = 65 - FRACTION_BITS;

   logic [63:0]   prod_ff;
   logic          neg_ff;
   result_type    res_ff;
   result_type    res_in;
   logic [64:0]   rnd;
   logic [MW-1:0] m;

   always_comb begin
      rnd = {1'b0, prod_ff} + (65'd1 << (FRACTION_BITS - 1));
      m   = MW'(rnd >> FRACTION_BITS);
      res_in.cond = 1'b0;
      if (neg_ff ? (m > MW'(64'h8000_0000)) : (m > MW'(64'h7FFF_FFFF))) begin
         res_in.value = neg_ff ? Q_MIN : Q_MAX;
         res_in.err   = ERR_OVF;
      end else begin
         res_in.value = neg_ff ? -$signed(m[31:0]) : $signed(m[31:0]);
         res_in.err   = ERR_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= mag_a * mag_b;
         neg_ff  <= neg;
         res_ff  <= res_in;
      end
   end

   assign res = res_ff;

endmodule

### rtl/core/q248_div.sv
module q248_div #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                clock,
   input  logic                en,
   input  logic [31:0]         mag_a,
   input  logic [31:0]         mag_b,
   input  logic                neg,
   output q248_pkg::result_type res
);
   import q248_pkg::*;

   localparam int NQ = 32 + FRACTION_BITS;

   // Each stage retires one quotient bit; the shift word loses a numerator
   // bit at the top and gains a quotient bit at the bottom.
   logic [31:0]   rem_ff [NQ];
   logic [NQ-1:0] wrd_ff [NQ];
   logic [31:0]   den_ff [NQ];
   logic          neg_ff [NQ];
   result_type    res_ff;
   result_type    res_in;
   logic [NQ:0]   m;

   genvar k;
   generate
      for (k = 0; k < NQ; k++) begin : g_step
         logic [31:0]   r_prev;
         logic [NQ-1:0] w_prev;
         logic [31:0]   d_prev;
         logic          n_prev;
         logic [32:0]   t;
         logic          ge;
         if (k == 0) begin : g_first
            assign r_prev = '0;
            assign w_prev = {mag_a, FRACTION_BITS'(0)};
            assign d_prev = mag_b;
            assign n_prev = neg;
         end else begin : g_next
            assign r_prev = rem_ff[k-1];
            assign w_prev = wrd_ff[k-1];
            assign d_prev = den_ff[k-1];
            assign n_prev = neg_ff[k-1];
         end
         assign t  = {r_prev, w_prev[NQ-1]};
         assign ge = t >= {1'b0, d_prev};
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= ge ? 32'(t - {1'b0, d_prev}) : t[31:0];
               wrd_ff[k] <= {w_prev[NQ-2:0], ge};
               den_ff[k] <= d_prev;
               neg_ff[k] <= n_prev;
            end
         end
      end
   endgenerate

   always_comb begin
      m = {1'b0, wrd_ff[NQ-1]}
          + (NQ+1)'({rem_ff[NQ-1], 1'b0} >= {1'b0, den_ff[NQ-1]});
      res_in.cond = 1'b0;
      if (den_ff[NQ-1] == '0) begin
         res_in.value = '0;
         res_in.err   = ERR_DIV0;
      end else if (neg_ff[NQ-1] ? (m > (NQ+1)'(64'h8000_0000))
                                : (m > (NQ+1)'(64'h7FFF_FFFF))) begin
         res_in.value = neg_ff[NQ-1] ? Q_MIN : Q_MAX;
         res_in.err   = ERR_OVF;
      end else begin
         res_in.value = neg_ff[NQ-1] ? -$signed(m[31:0]) : $signed(m[31:0]);
         res_in.err   = ERR_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

### rtl/core/q24_8_fixed_point_alu_top.sv
// Channel  Direction  Word fields (lowest bit first)
// req      in         opcode[3:0], operand_a[35:4], operand_b[67:36], zero fill to 72
// rsp      out        result_value[31:0], condition[32], error_code[34:33], zero fill to 40
//
// Every word follows the divider's path: the input register, the quotient stages and
// the divider's result register, then the output register; the divider resolves one
// quotient bit per stage. A new word is accepted every cycle while the pipe advances.
// All stages advance together whenever the output register is empty or being drained,
// so a stall on rsp holds the whole pipe without loss. Reset clears only the valid bits.
module q24_8_fixed_point_alu_top #(
   parameter int FRACTION_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // opcode, operand_a, operand_b
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // result_value, condition, error_code
);
   import q248_pkg::*;

   localparam int NQ = 32 + FRACTION_BITS;
   localparam int LN = NQ + 2;   // stages from input register to divider output

   typedef struct packed {
      opcode_type op;
      result_type res;
   } line_type;

   logic        en;
   logic        vld_ff [LN];
   line_type    line_ff [LN];
   line_type    line_in;
   logic [31:0] mag_a_ff, mag_b_ff, mag_a_in, mag_b_in;
   logic        neg_ff, neg_in;
   result_type  mul_res, div_res;
   result_type  mdl_ff [NQ-1];
   result_type  out_ff, out_in;
   logic        out_vld_ff;

   logic signed [31:0] a, b;
   logic               lt;
   logic [FRACTION_BITS:0] top_bits;

   // The whole pipe moves as one whenever the output word is free or leaving.
   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   assign a        = $signed(req_tdata[35:4]);
   assign b        = $signed(req_tdata[67:36]);
   assign lt       = a < b;
   assign top_bits = a[31:31-FRACTION_BITS];

   // Magnitudes and sign feed the multiplier and the divider.
   always_comb begin
      mag_a_in = a[31] ? 32'(-a) : 32'(a);
      mag_b_in = b[31] ? 32'(-b) : 32'(b);
      neg_in   = a[31] != b[31];
   end

   // Operations other than multiply and divide are finished in the input stage.
   always_comb begin
      line_in.op        = opcode_type'(req_tdata[3:0]);
      line_in.res.value = '0;
      line_in.res.cond  = 1'b0;
      line_in.res.err   = ERR_OK;
      case (line_in.op)
         OP_ADD:     line_in.res = sat33(33'(a) + 33'(b));
         OP_SUB:     line_in.res = sat33(33'(a) - 33'(b));
         OP_MIN:     line_in.res.value = lt ? a : b;
         OP_MAX:     line_in.res.value = (a > b) ? a : b;
         OP_LT:      line_in.res.cond = lt;
         OP_LE:      line_in.res.cond = a <= b;
         OP_GT:      line_in.res.cond = a > b;
         OP_GE:      line_in.res.cond = !lt;
         OP_EQ:      line_in.res.cond = a == b;
         OP_NE:      line_in.res.cond = a != b;
         OP_INC:     line_in.res = sat33(33'(a) + 33'sd1);
         OP_DEC:     line_in.res = sat33(33'(a) - 33'sd1);
         OP_TOINT:   line_in.res.value = a >>> FRACTION_BITS;
         OP_FROMINT: begin
            // The shift fits only when the discarded bits all match the sign.
            if (top_bits == '0 || top_bits == '1) begin
               line_in.res.value = a <<< FRACTION_BITS;
            end else begin
               line_in.res.value = a[31] ? Q_MIN : Q_MAX;
               line_in.res.err   = ERR_OVF;
            end
         end
         OP_MUL, OP_DIV: line_in.res.value = '0;
         default:    line_in.res.value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LN; i++) begin
            vld_ff[i] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < LN; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         out_vld_ff <= vld_ff[LN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= line_in;
         mag_a_ff   <= mag_a_in;
         mag_b_ff   <= mag_b_in;
         neg_ff     <= neg_in;
         for (int i = 1; i < LN; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
         // The product leaves its unit early and waits here for the divider.
         mdl_ff[0] <= mul_res;
         for (int i = 1; i < NQ - 1; i++) begin
            mdl_ff[i] <= mdl_ff[i-1];
         end
         out_ff <= out_in;
      end
   end

   q248_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
      .clock (clock),
      .en    (en),
      .mag_a (mag_a_ff),
      .mag_b (mag_b_ff),
      .neg   (neg_ff),
      .res   (mul_res)
   );

   q248_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock (clock),
      .en    (en),
      .mag_a (mag_a_ff),
      .mag_b (mag_b_ff),
      .neg   (neg_ff),
      .res   (div_res)
   );

   always_comb begin
      case (line_ff[LN-1].op)
         OP_MUL:  out_in = mdl_ff[NQ-2];
         OP_DIV:  out_in = div_res;
         default: out_in = line_ff[LN-1].res;
      endcase
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'd0, out_ff.err, out_ff.cond, out_ff.value};

endmodule
